// File: src/assert_macros.svh
// Assertion shorthands shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a implies b on the same edge
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("implication check failed");

// a never holds
`define ASSERT_NEVER(label, clk, rst_n, a) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(a)) \
        else $error("forbidden condition seen");

`endif

// File: src/hntd_pkg.sv
package hntd_pkg;

    // default table depth
    localparam int NODES_DEF = 512;

    localparam int SYM_W = 16;

    // child value that marks a leaf / no child
    localparam logic [SYM_W-1:0] LEAF_MARK = 16'hFFFF;

    // input operation codes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_ROOT   = 2'd0,
        CFG_COUNT  = 2'd1,
        CFG_MAXLEN = 2'd2
    } cfg_idx_t;

    // walker to result buffer
    typedef struct packed {
        logic             push;
        logic             flush;
        logic [SYM_W-1:0] sym;
        logic             str_end;
    } buf_cmd_t;

    // result buffer to walker
    typedef struct packed {
        logic ok;
        logic pend_valid;
    } buf_stat_t;

endpackage

// File: src/huffman_node_table_decoder.sv
// Load item, or a decode while no string is open: one cycle, next item taken at once.
// Decode item: accept step (current node read), first child read, then a node read per
// bit walked, a root re-read per symbol found before the final bit walked, and a closing
// flush step; a held result stalls the walk. The next item is taken only once the walk is
// back in idle; one read port sets the pace.
// Reset clears control and configuration; the node table is undefined until written.
`include "assert_macros.svh"

module huffman_node_table_decoder
    import hntd_pkg::*;
#(
    parameter int NODES = NODES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    // configuration write port
    input  logic             cfg_write_en,
    input  logic [1:0]       cfg_index,
    input  logic [15:0]      cfg_data,
    // input items
    input  logic             item_valid,
    output logic             item_ready,
    input  logic             op,
    input  logic [8:0]       node_index,
    input  logic [15:0]      left_child,
    input  logic [15:0]      right_child,
    input  logic [15:0]      symbol,
    input  logic [7:0]       data_byte,
    input  logic [2:0]       first_bit,
    input  logic             start_string,
    // results
    output logic             result_valid,
    input  logic             result_ready,
    output logic [SYM_W-1:0] decoded_symbol,
    output logic             string_end,
    output logic             last
);

    localparam int AW = $clog2(NODES);
    localparam int CW = (AW > 9) ? AW : 9;
    localparam logic [15:0] NODES_W = 16'(NODES);

    typedef struct packed {
        logic [SYM_W-1:0] left;
        logic [SYM_W-1:0] right;
        logic [SYM_W-1:0] sym;
    } node_t;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WALK  = 4'b0010,
        S_TEST  = 4'b0100,
        S_FLUSH = 4'b1000
    } state_t;

    state_t      state_reg, state_next;
    logic [8:0]  root_reg;
    logic [9:0]  count_cfg_reg;
    logic [15:0] maxlen_reg;
    logic [CW-1:0] cur_reg, cur_next;
    logic [15:0] sym_cnt_reg, sym_cnt_next;
    logic        done_reg, done_next;
    logic [7:0]  data_reg, data_next;
    logic [2:0]  pos_reg, pos_next;
    logic [CW-1:0] nidx_reg, nidx_next;
    logic        nin_reg, nin_next;

    node_t       mem [NODES];
    node_t       rd_q;
    logic        rd_en;
    logic [AW-1:0] rd_addr;
    logic        wr_en;

    logic [15:0] cnt16;
    logic [15:0] limit;
    logic        cur_in;
    logic [2:0]  pos_inc;
    logic [15:0] child_w;
    logic [15:0] child_t;
    logic        leaf;
    logic [15:0] leaf_sym;
    logic        str_end;
    logic        accept;
    buf_cmd_t    cmd;
    buf_stat_t   stat;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg      <= '0;
            count_cfg_reg <= '0;
            maxlen_reg    <= 16'hFFFF;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_ROOT:   root_reg      <= cfg_data[8:0];
                CFG_COUNT:  count_cfg_reg <= cfg_data[9:0];
                CFG_MAXLEN: maxlen_reg    <= cfg_data;
                default:    ;
            endcase
        end
    end

    // effective node count and length limit
    assign cnt16 = ({6'd0, count_cfg_reg} < NODES_W) ? {6'd0, count_cfg_reg} : NODES_W;
    assign limit = (maxlen_reg == 16'd0) ? 16'd1 : maxlen_reg;

    assign item_ready = (state_reg == S_IDLE);
    assign accept     = item_valid && item_ready;
    assign wr_en      = accept && (op == OP_LOAD) && (16'(node_index) < NODES_W);

    // node table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[AW'(node_index)] <= '{left: left_child, right: right_child, sym: symbol};
        end
        if (rd_en)
        begin
            rd_q <= mem[rd_addr];
        end
    end

    // child selection: from the current node, or straight on from a non-leaf
    assign cur_in   = 16'(cur_reg) < cnt16;
    assign child_w  = !cur_in ? LEAF_MARK
                    : (data_reg[pos_reg] ? rd_q.left : rd_q.right);
    assign pos_inc  = pos_reg + 3'd1;
    assign child_t  = data_reg[pos_inc] ? rd_q.left : rd_q.right;

    // leaf test on the node just read
    assign leaf     = !nin_reg || (rd_q.right == LEAF_MARK);
    assign leaf_sym = nin_reg ? rd_q.sym : 16'd0;
    assign str_end  = (leaf_sym == 16'd0) || ((sym_cnt_reg + 16'd1) >= limit);

    // walk sequencer
    always_comb
    begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        sym_cnt_next = sym_cnt_reg;
        done_next    = done_reg;
        data_next    = data_reg;
        pos_next     = pos_reg;
        nidx_next    = nidx_reg;
        nin_next     = nin_reg;
        rd_en        = 1'b0;
        rd_addr      = AW'(cur_reg);
        cmd          = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (op == OP_DECODE))
                begin
                    if (start_string)
                    begin
                        cur_next     = CW'(root_reg);
                        sym_cnt_next = '0;
                        done_next    = 1'b0;
                    end
                    if (start_string || !done_reg)
                    begin
                        data_next  = data_byte;
                        pos_next   = first_bit;
                        rd_en      = 1'b1;
                        rd_addr    = start_string ? AW'(root_reg) : AW'(cur_reg);
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                rd_en      = 1'b1;
                rd_addr    = AW'(child_w);
                nidx_next  = CW'(child_w);
                nin_next   = child_w < cnt16;
                state_next = S_TEST;
            end
            S_TEST:
            begin
                if (!leaf)
                begin
                    cur_next = nidx_reg;
                    if (pos_reg == 3'd7)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        // entry of the new current node is already in hand
                        pos_next  = pos_inc;
                        rd_en     = 1'b1;
                        rd_addr   = AW'(child_t);
                        nidx_next = CW'(child_t);
                        nin_next  = child_t < cnt16;
                    end
                end
                else if (stat.ok)
                begin
                    cmd.push     = 1'b1;
                    cmd.sym      = leaf_sym;
                    cmd.str_end  = str_end;
                    sym_cnt_next = sym_cnt_reg + 16'd1;
                    cur_next     = CW'(root_reg);
                    if (str_end)
                    begin
                        done_next  = 1'b1;
                        state_next = S_FLUSH;
                    end
                    else if (pos_reg == 3'd7)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        pos_next   = pos_inc;
                        rd_en      = 1'b1;
                        rd_addr    = AW'(root_reg);
                        state_next = S_WALK;
                    end
                end
            end
            S_FLUSH:
            begin
                if (stat.ok)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cur_reg     <= '0;
            sym_cnt_reg <= '0;
            done_reg    <= 1'b1;
        end
        else
        begin
            state_reg   <= state_next;
            cur_reg     <= cur_next;
            sym_cnt_reg <= sym_cnt_next;
            done_reg    <= done_next;
        end
    end

    // per-item working registers
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        pos_reg  <= pos_next;
        nidx_reg <= nidx_next;
        nin_reg  <= nin_next;
    end

    hntd_out_buf u_out_buf
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .decoded_symbol (decoded_symbol),
        .string_end     (string_end),
        .last           (last)
    );

    `ASSERT_IMPLY(a_idle_no_pend, clk, rst_n, state_reg == S_IDLE, !stat.pend_valid)
    `ASSERT_IMPLY(a_end_is_last, clk, rst_n, result_valid && string_end, last)

endmodule

// File: src/hntd_out_buf.sv
`include "assert_macros.svh"

// Holds the newest symbol back until it is known whether it is the last of
// its item, then passes it on through the output register.
module hntd_out_buf
    import hntd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  buf_cmd_t         cmd,
    output buf_stat_t        stat,
    output logic             result_valid,
    input  logic             result_ready,
    output logic [SYM_W-1:0] decoded_symbol,
    output logic             string_end,
    output logic             last
);

    logic             pend_valid_reg, pend_valid_next;
    logic [SYM_W-1:0] pend_sym_reg, pend_sym_next;
    logic             pend_end_reg, pend_end_next;
    logic             out_valid_reg, out_valid_next;
    logic [SYM_W-1:0] out_sym_reg, out_sym_next;
    logic             out_end_reg, out_end_next;
    logic             out_last_reg, out_last_next;
    logic             out_free;

    // output slot frees when empty or being transferred
    assign out_free        = !out_valid_reg || result_ready;
    assign stat.ok         = !pend_valid_reg || out_free;
    assign stat.pend_valid = pend_valid_reg;

    // next-state logic
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        pend_end_next   = pend_end_reg;
        out_valid_next  = out_valid_reg && !result_ready;
        out_sym_next    = out_sym_reg;
        out_end_next    = out_end_reg;
        out_last_next   = out_last_reg;
        if (cmd.push)
        begin
            // older symbol moves on, more follow in this item
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_sym_next   = pend_sym_reg;
                out_end_next   = pend_end_reg;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_sym_next   = cmd.sym;
            pend_end_next   = cmd.str_end;
        end
        else if (cmd.flush && pend_valid_reg)
        begin
            // item finished: held symbol is its last
            out_valid_next  = 1'b1;
            out_sym_next    = pend_sym_reg;
            out_end_next    = pend_end_reg;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        pend_sym_reg <= pend_sym_next;
        pend_end_reg <= pend_end_next;
        out_sym_reg  <= out_sym_next;
        out_end_reg  <= out_end_next;
        out_last_reg <= out_last_next;
    end

    assign result_valid   = out_valid_reg;
    assign decoded_symbol = out_sym_reg;
    assign string_end     = out_end_reg;
    assign last           = out_last_reg;

    `ASSERT_IMPLY(a_cmd_when_ok, clk, rst_n, cmd.push || cmd.flush, stat.ok)
    `ASSERT_NEVER(a_push_flush, clk, rst_n, cmd.push && cmd.flush)

endmodule
